FILE: rtl/core/csvfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csvfd_pkg;

    // Characters that steer the scanner
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // UTF-8 byte order mark
    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    // Mark matcher phases: bytes of the mark seen so far
    localparam logic [1:0] BOM_PH_START = 2'd0;
    localparam logic [1:0] BOM_PH_LAST  = 2'd2;
    localparam logic [1:0] BOM_PH_NONE  = 2'd3;

    localparam int FIFO_DEPTH_DEF = 4;

    // One queue entry: held mark bytes to release, then the scan result of the byte
    typedef struct packed {
        logic [1:0] held;
        logic       scan_emit;
        logic [7:0] data;
        logic       data_valid;
        logic       cell_end;
        logic       row_end;
    } entry_t;

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       cell_end;
        logic       row_end;
        logic       last;
    } result_t;

    function automatic logic [7:0] bom_byte(input logic [1:0] ph);
        logic [7:0] b;
        unique case (ph)
            2'd0:    b = BOM_B0;
            2'd1:    b = BOM_B1;
            2'd2:    b = BOM_B2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/csv_field_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming CSV tokenizer, one byte per item.
// Input channel: drive in_byte and stream_start with push; the byte is taken
// at a rising edge with push high and full low. stream_start restarts the
// parser (mark detection and cell state) before that byte.
// Result channel: while empty is low the oldest result sits on out_byte,
// byte_valid, cell_end, row_end and run_last; pop takes it. run_last marks
// the last result caused by one input byte.
// The front classifies each byte and writes at most one entry into a small
// queue; the back expands an entry into one to three results through an
// output register. A byte's entry is written into the queue as the byte is
// accepted; its results then pass from the queue to the output register.
// Throughput is one byte per cycle while full is low; a byte that releases a
// partly matched byte order mark yields up to three results, which leave one
// per cycle while pop is high. A byte order mark or an opening quote yields
// no result at all. When the receiver holds pop low, the output register
// holds its result and the queue fills; full rises once FIFO_DEPTH entries
// wait. Reset clears the queue and the output register and leaves the parser
// expecting a byte order mark at the start of a fresh cell.
module csv_field_deframer_core #(
    parameter int FIFO_DEPTH = csvfd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       stream_start,
    input  wire logic       push,
    output logic            full,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            cell_end,
    output logic            row_end,
    output logic            run_last,
    output logic            empty,
    input  wire logic       pop
);
    import csvfd_pkg::*;

    entry_t  entry;
    entry_t  head;
    logic    entry_push;
    logic    q_full;
    logic    q_empty;
    logic    head_pop;
    logic    accept;
    result_t result;

    // Take a byte whenever the queue has room
    assign accept = push && !q_full;
    assign full   = q_full;

    csvfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .accept       (accept),
        .entry_push   (entry_push),
        .entry        (entry)
    );

    csvfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (entry_push),
        .wr_data (entry),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    csvfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    // Drive the result ports from the output register
    assign out_byte   = result.data;
    assign byte_valid = result.byte_valid;
    assign cell_end   = result.cell_end;
    assign row_end    = result.row_end;
    assign run_last   = result.last;

endmodule

`default_nettype wire

FILE: rtl/core/csvfd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module csvfd_fifo #(
    parameter int DEPTH = csvfd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire csvfd_pkg::entry_t wr_data,
    input  wire logic             rd_en,
    output csvfd_pkg::entry_t     rd_data,
    output logic                  full,
    output logic                  empty
);
    import csvfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/csvfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module csvfd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        in_byte,
    input  wire logic              stream_start,
    input  wire logic              accept,
    output logic                   entry_push,
    output csvfd_pkg::entry_t      entry
);
    import csvfd_pkg::*;

    logic [1:0] bom_phase_reg, bom_phase_next;
    logic       bom_active_reg, bom_active_next;
    logic       cell_fresh_reg, cell_fresh_next;
    logic       cell_quoted_reg, cell_quoted_next;
    logic       inside_quotes_reg, inside_quotes_next;
    logic       quote_held_reg, quote_held_next;

    // Classify the byte: mark matching first, then the cell scanner
    always_comb
    begin
        logic       b_active;
        logic [1:0] b_phase;
        logic       fr;
        logic       qd;
        logic       iq;
        logic       qh;
        logic       scan_en;
        logic [1:0] held;
        logic       emit;
        logic [7:0] data;
        logic       dvalid;
        logic       ce;
        logic       re;

        b_active = stream_start ? 1'b1 : bom_active_reg;
        b_phase  = stream_start ? BOM_PH_START : bom_phase_reg;
        fr       = stream_start ? 1'b1 : cell_fresh_reg;
        qd       = stream_start ? 1'b0 : cell_quoted_reg;
        iq       = stream_start ? 1'b0 : inside_quotes_reg;
        qh       = stream_start ? 1'b0 : quote_held_reg;

        bom_active_next = b_active;
        bom_phase_next  = b_phase;
        scan_en         = 1'b1;
        held            = 2'd0;
        emit            = 1'b0;
        data            = 8'h00;
        dvalid          = 1'b0;
        ce              = 1'b0;
        re              = 1'b0;

        if (b_active)
        begin
            if (b_phase != BOM_PH_NONE && in_byte == bom_byte(b_phase))
            begin
                scan_en = 1'b0;
                if (b_phase == BOM_PH_LAST)
                begin
                    bom_active_next = 1'b0;
                    bom_phase_next  = BOM_PH_START;
                end
                else
                begin
                    bom_phase_next = b_phase + 2'd1;
                end
            end
            else
            begin
                bom_active_next = 1'b0;
                bom_phase_next  = BOM_PH_START;
                held            = (b_phase == BOM_PH_NONE) ? BOM_PH_LAST : b_phase;
                // released mark bytes are plain content in a fresh cell
                if (held != 2'd0)
                begin
                    fr = 1'b0;
                    qh = 1'b0;
                end
            end
        end

        if (scan_en)
        begin
            priority if (fr && in_byte == CH_QUOTE)
            begin
                fr = 1'b0;
                qd = 1'b1;
                iq = 1'b1;
            end
            else if (qd && iq)
            begin
                if (in_byte == CH_QUOTE)
                begin
                    iq = 1'b0;
                    qh = 1'b1;
                end
                else
                begin
                    emit   = 1'b1;
                    data   = in_byte;
                    dvalid = 1'b1;
                end
            end
            else if (qd && qh && in_byte == CH_QUOTE)
            begin
                emit   = 1'b1;
                data   = CH_QUOTE;
                dvalid = 1'b1;
                qh     = 1'b0;
                iq     = 1'b1;
            end
            else if (in_byte == CH_COMMA || in_byte == CH_NL)
            begin
                emit = 1'b1;
                ce   = 1'b1;
                re   = (in_byte == CH_NL);
                fr   = 1'b1;
                qd   = 1'b0;
                iq   = 1'b0;
                qh   = 1'b0;
            end
            else
            begin
                qh = 1'b0;
                if (qd && in_byte == CH_QUOTE)
                begin
                    iq = 1'b1;
                end
                else
                begin
                    emit   = 1'b1;
                    data   = in_byte;
                    dvalid = 1'b1;
                    fr     = 1'b0;
                end
            end
        end

        cell_fresh_next    = fr;
        cell_quoted_next   = qd;
        inside_quotes_next = iq;
        quote_held_next    = qh;

        entry.held       = held;
        entry.scan_emit  = emit;
        entry.data       = data;
        entry.data_valid = dvalid;
        entry.cell_end   = ce;
        entry.row_end    = re;
        entry_push       = accept && (held != 2'd0 || emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bom_phase_reg     <= BOM_PH_START;
            bom_active_reg    <= 1'b1;
            cell_fresh_reg    <= 1'b1;
            cell_quoted_reg   <= 1'b0;
            inside_quotes_reg <= 1'b0;
            quote_held_reg    <= 1'b0;
        end
        else if (accept)
        begin
            bom_phase_reg     <= bom_phase_next;
            bom_active_reg    <= bom_active_next;
            cell_fresh_reg    <= cell_fresh_next;
            cell_quoted_reg   <= cell_quoted_next;
            inside_quotes_reg <= inside_quotes_next;
            quote_held_reg    <= quote_held_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/csvfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module csvfd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csvfd_pkg::entry_t head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    input  wire logic              pop,
    output logic                   empty,
    output csvfd_pkg::result_t     result
);
    import csvfd_pkg::*;

    logic [1:0] sub_idx_reg, sub_idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    cur;
    logic       load;

    // Expand the head entry: held mark bytes first, then the scan result
    always_comb
    begin
        if (sub_idx_reg < head.held)
        begin
            cur.data       = (sub_idx_reg == 2'd0) ? BOM_B0 : BOM_B1;
            cur.byte_valid = 1'b1;
            cur.cell_end   = 1'b0;
            cur.row_end    = 1'b0;
            cur.last       = (sub_idx_reg == head.held - 2'd1) && !head.scan_emit;
        end
        else
        begin
            cur.data       = head.data;
            cur.byte_valid = head.data_valid;
            cur.cell_end   = head.cell_end;
            cur.row_end    = head.row_end;
            cur.last       = 1'b1;
        end
    end

    assign load     = head_valid && (!out_valid_reg || pop);
    assign head_pop = load && cur.last;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        sub_idx_next   = sub_idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            sub_idx_next   = cur.last ? 2'd0 : sub_idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_idx_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_idx_reg   <= sub_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= cur;
        end
    end

`ifndef ASSERT_OFF
    a_cell_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.cell_end) |-> out_reg.last)
        else $error("cell end result not last of its item");

    a_row_with_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.row_end) |-> (out_reg.cell_end && !out_reg.byte_valid))
        else $error("row end without cell end");

    a_sub_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_idx_reg != 2'd3))
        else $error("expansion index out of range");

    a_idx_resets: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> (sub_idx_reg == 2'd0))
        else $error("expansion index not cleared after entry retired");
`endif

endmodule

`default_nettype wire
